FILE: hdl/bounded_deque_with_search_macros.svh
`ifndef BOUNDED_DEQUE_WITH_SEARCH_MACROS_SVH
`define BOUNDED_DEQUE_WITH_SEARCH_MACROS_SVH

// Concurrent check on the rising edge of clk, switched off while reset is held.
`define BDQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Concurrent check on the rising edge of clk that also holds during reset.
`define BDQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: hdl/bdq_pkg.sv
`default_nettype none

package bdq_pkg;

  localparam int DEPTH_DEF = 16;

  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_BACK   = 3'd3;
  localparam logic [2:0] OP_SEARCH     = 3'd4;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  localparam logic [2:0] ASEL_FRONT      = 3'd0;
  localparam logic [2:0] ASEL_FRONT_PREV = 3'd1;
  localparam logic [2:0] ASEL_BACK_NEW   = 3'd2;
  localparam logic [2:0] ASEL_BACK_LAST  = 3'd3;
  localparam logic [2:0] ASEL_SCAN_NEXT  = 3'd4;

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] removed_value;
    logic [3:0]         found_position;
    logic [4:0]         entry_count;
  } out_item_t;

  typedef struct packed {
    logic       load;
    logic [2:0] addr_sel;
    logic       mem_wr;
    logic       front_dec;
    logic       front_inc;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       scan_clr;
    logic       scan_inc;
    logic       respond;
    logic [1:0] res_status;
    logic       take_removed;
    logic       take_position;
  } cmd_t;

  typedef struct packed {
    logic [2:0] opcode;
    logic       full;
    logic       empty;
    logic       match;
    logic       last;
  } stat_t;

endpackage

`default_nettype wire

FILE: hdl/bdq_ctrl.sv
`default_nettype none
`include "bounded_deque_with_search_macros.svh"

module bdq_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  output logic               out_valid,
  input  wire bdq_pkg::stat_t stat,
  output bdq_pkg::cmd_t      cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_POP  = 2'd2;
  localparam logic [1:0] S_SRCH = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
        unique case (stat.opcode)
          bdq_pkg::OP_PUSH_FRONT: begin
            cmd.respond = 1'b1;
            if (stat.full) begin
              cmd.res_status = bdq_pkg::ST_FULL;
            end else begin
              cmd.res_status = bdq_pkg::ST_DONE;
              cmd.addr_sel   = bdq_pkg::ASEL_FRONT_PREV;
              cmd.mem_wr     = 1'b1;
              cmd.front_dec  = 1'b1;
              cmd.cnt_inc    = 1'b1;
            end
          end
          bdq_pkg::OP_PUSH_BACK: begin
            cmd.respond = 1'b1;
            if (stat.full) begin
              cmd.res_status = bdq_pkg::ST_FULL;
            end else begin
              cmd.res_status = bdq_pkg::ST_DONE;
              cmd.addr_sel   = bdq_pkg::ASEL_BACK_NEW;
              cmd.mem_wr     = 1'b1;
              cmd.cnt_inc    = 1'b1;
            end
          end
          bdq_pkg::OP_POP_FRONT: begin
            if (stat.empty) begin
              cmd.respond    = 1'b1;
              cmd.res_status = bdq_pkg::ST_EMPTY;
            end else begin
              cmd.addr_sel  = bdq_pkg::ASEL_FRONT;
              cmd.front_inc = 1'b1;
              cmd.cnt_dec   = 1'b1;
              state_nxt     = S_POP;
            end
          end
          bdq_pkg::OP_POP_BACK: begin
            if (stat.empty) begin
              cmd.respond    = 1'b1;
              cmd.res_status = bdq_pkg::ST_EMPTY;
            end else begin
              cmd.addr_sel = bdq_pkg::ASEL_BACK_LAST;
              cmd.cnt_dec  = 1'b1;
              state_nxt    = S_POP;
            end
          end
          bdq_pkg::OP_SEARCH: begin
            if (stat.empty) begin
              cmd.respond    = 1'b1;
              cmd.res_status = bdq_pkg::ST_NOT_FOUND;
            end else begin
              cmd.addr_sel = bdq_pkg::ASEL_FRONT;
              cmd.scan_clr = 1'b1;
              state_nxt    = S_SRCH;
            end
          end
          default: begin
            cmd.respond    = 1'b1;
            cmd.res_status = bdq_pkg::ST_DONE;
          end
        endcase
      end
      S_POP: begin
        cmd.respond      = 1'b1;
        cmd.res_status   = bdq_pkg::ST_DONE;
        cmd.take_removed = 1'b1;
        state_nxt        = S_IDLE;
      end
      S_SRCH: begin
        cmd.addr_sel = bdq_pkg::ASEL_SCAN_NEXT;
        cmd.scan_inc = 1'b1;
        priority if (stat.match) begin
          cmd.respond       = 1'b1;
          cmd.res_status    = bdq_pkg::ST_DONE;
          cmd.take_position = 1'b1;
          state_nxt         = S_IDLE;
        end else if (stat.last) begin
          cmd.respond    = 1'b1;
          cmd.res_status = bdq_pkg::ST_NOT_FOUND;
          state_nxt      = S_IDLE;
        end else begin
          state_nxt = S_SRCH;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= cmd.respond;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  `BDQ_ASSERT(a_strobe_single, out_valid_r |=> !out_valid_r, "result strobe held for two cycles")
  `BDQ_ASSERT(a_idle_with_result, $fell(busy) |-> out_valid_r, "block went idle without a result")
  `BDQ_ASSERT(a_start_takes, (start && !busy) |=> busy, "accepted beat did not raise busy")

endmodule

`default_nettype wire

FILE: hdl/bdq_dp.sv
`default_nettype none
`include "bounded_deque_with_search_macros.svh"

module bdq_dp #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire bdq_pkg::in_item_t  in_item,
  input  wire bdq_pkg::cmd_t      cmd,
  output bdq_pkg::stat_t          stat,
  output bdq_pkg::out_item_t      out_item
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  function automatic logic [IDX_W-1:0] ring_slot(input logic [IDX_W-1:0] base,
                                                 input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(off);
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rdata_r;
  bdq_pkg::in_item_t  item_r;
  bdq_pkg::out_item_t res_r, res_nxt;
  logic [IDX_W-1:0]   front_r, front_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [IDX_W-1:0]   scan_r, scan_nxt;
  logic [CNT_W-1:0]   scan_succ;
  logic [CNT_W-1:0]   addr_off;
  logic [CNT_W-1:0]   front_off;
  logic [IDX_W-1:0]   addr;
  logic [31:0]        pos_ext;
  logic [31:0]        cnt_ext;

  assign scan_succ = CNT_W'(scan_r) + CNT_W'(1);

  always_comb begin
    unique case (cmd.addr_sel)
      bdq_pkg::ASEL_FRONT:      addr_off = '0;
      bdq_pkg::ASEL_FRONT_PREV: addr_off = CNT_W'(DEPTH - 1);
      bdq_pkg::ASEL_BACK_NEW:   addr_off = count_r;
      bdq_pkg::ASEL_BACK_LAST:  addr_off = count_r - CNT_W'(1);
      bdq_pkg::ASEL_SCAN_NEXT:  addr_off = scan_succ;
      default:                  addr_off = '0;
    endcase
  end

  assign addr      = ring_slot(front_r, addr_off);
  assign front_off = cmd.front_dec ? CNT_W'(DEPTH - 1) : CNT_W'(1);

  always_comb begin
    front_nxt = front_r;
    if (cmd.front_dec || cmd.front_inc) begin
      front_nxt = ring_slot(front_r, front_off);
    end
    count_nxt = count_r;
    if (cmd.cnt_inc) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.cnt_dec) begin
      count_nxt = count_r - CNT_W'(1);
    end
    scan_nxt = scan_r;
    if (cmd.scan_clr) begin
      scan_nxt = '0;
    end else if (cmd.scan_inc) begin
      scan_nxt = scan_succ[IDX_W-1:0];
    end
  end

  assign pos_ext = 32'(scan_r);
  assign cnt_ext = 32'(count_nxt);

  always_comb begin
    res_nxt                = res_r;
    res_nxt.status         = cmd.res_status;
    res_nxt.removed_value  = cmd.take_removed ? rdata_r : 32'sd0;
    res_nxt.found_position = cmd.take_position ? pos_ext[3:0] : 4'd0;
    res_nxt.entry_count    = cnt_ext[4:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      mem[addr] <= item_r.value;
    end
    rdata_r <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_item;
    end
    if (cmd.respond) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      count_r <= '0;
      scan_r  <= '0;
    end else begin
      front_r <= front_nxt;
      count_r <= count_nxt;
      scan_r  <= scan_nxt;
    end
  end

  assign stat.opcode = item_r.opcode;
  assign stat.full   = (count_r == CNT_W'(DEPTH));
  assign stat.empty  = (count_r == '0);
  assign stat.match  = (rdata_r == item_r.value);
  assign stat.last   = (scan_succ == count_r);

  assign out_item = res_r;

  `BDQ_ASSERT_ALWAYS(a_count_bound, !rst_n || count_r <= CNT_W'(DEPTH), "entry count above depth")
  `BDQ_ASSERT(a_no_push_full, cmd.mem_wr |-> !stat.full, "write issued into a full store")

endmodule

`default_nettype wire

FILE: hdl/bounded_deque_with_search.sv
// Push, unused opcode or refused pop/search: the result strobe is registered from the execute state;
// the next beat is taken only once the block is idle again, never before the last result.
// Pop: the removed value comes from a registered memory read, and the result from a separate pop state.
// Search: the scan reads one entry from memory per cycle, starting at the front, and stops at the
// first match or after the last entry.
// Synchronous active-low reset empties the store; the receiver cannot stall the result.
`default_nettype none

module bounded_deque_with_search #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire bdq_pkg::in_item_t in_item,
  output logic                   out_valid,
  output bdq_pkg::out_item_t     out_item
);

  bdq_pkg::cmd_t  cmd;
  bdq_pkg::stat_t stat;

  bdq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  bdq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cmd      (cmd),
    .stat     (stat),
    .out_item (out_item)
  );

endmodule

`default_nettype wire

FILE: test/tb_bounded_deque_with_search.sv
`timescale 1ns / 1ps

module tb_bounded_deque_with_search;

  localparam int DEPTH = bdq_pkg::DEPTH_DEF;

  localparam logic [2:0] OP_UNUSED_LO  = 3'd5;
  localparam logic [2:0] OP_UNUSED_MID = 3'd6;
  localparam logic [2:0] OP_UNUSED_HI  = 3'd7;

  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] VAL_ONES = 32'shFFFF_FFFF;
  localparam logic signed [31:0] VAL_A5 = 32'shA5A5_A5A5;

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [31:0] value;
    logic [4:0]         reps;
    logic               typed;
    bdq_pkg::out_item_t want;
  } plan_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  bdq_pkg::in_item_t  in_item = '0;
  logic               busy;
  logic               out_valid;
  bdq_pkg::out_item_t out_item;

  logic signed [31:0] ring_mem [DEPTH];
  int ring_front = 0;
  int ring_count = 0;

  bdq_pkg::out_item_t expected_q [$];
  int errors = 0;
  int idle_pct = 29;
  logic signed [31:0] hot_vals [8];

  plan_row_t plan [0:21] = '{
    '{bdq_pkg::OP_POP_FRONT,  32'sd0,   5'd1, 1'b1,
      '{bdq_pkg::ST_EMPTY,     32'sd0,  4'd0, 5'd0}},
    '{bdq_pkg::OP_POP_BACK,   32'sh5A5A_A5A5, 5'd1, 1'b1,
      '{bdq_pkg::ST_EMPTY,     32'sd0,  4'd0, 5'd0}},
    '{bdq_pkg::OP_SEARCH,     32'sd0,   5'd1, 1'b1,
      '{bdq_pkg::ST_NOT_FOUND, 32'sd0,  4'd0, 5'd0}},
    '{OP_UNUSED_LO,           VAL_ONES, 5'd1, 1'b1,
      '{bdq_pkg::ST_DONE,      32'sd0,  4'd0, 5'd0}},
    '{OP_UNUSED_HI,           32'sd0,   5'd1, 1'b1,
      '{bdq_pkg::ST_DONE,      32'sd0,  4'd0, 5'd0}},
    '{bdq_pkg::OP_PUSH_FRONT, VAL_MIN,  5'd1, 1'b1,
      '{bdq_pkg::ST_DONE,      32'sd0,  4'd0, 5'd1}},
    '{bdq_pkg::OP_PUSH_BACK,  VAL_MAX,  5'd1, 1'b1,
      '{bdq_pkg::ST_DONE,      32'sd0,  4'd0, 5'd2}},
    '{bdq_pkg::OP_SEARCH,     VAL_MAX,  5'd1, 1'b1,
      '{bdq_pkg::ST_DONE,      32'sd0,  4'd1, 5'd2}},
    '{bdq_pkg::OP_SEARCH,     VAL_MIN,  5'd1, 1'b1,
      '{bdq_pkg::ST_DONE,      32'sd0,  4'd0, 5'd2}},
    '{bdq_pkg::OP_SEARCH,     VAL_ONES, 5'd1, 1'b1,
      '{bdq_pkg::ST_NOT_FOUND, 32'sd0,  4'd0, 5'd2}},
    '{OP_UNUSED_MID,          VAL_MAX,  5'd1, 1'b1,
      '{bdq_pkg::ST_DONE,      32'sd0,  4'd0, 5'd2}},
    '{bdq_pkg::OP_POP_FRONT,  32'sd0,   5'd1, 1'b1,
      '{bdq_pkg::ST_DONE,      VAL_MIN, 4'd0, 5'd1}},
    '{bdq_pkg::OP_POP_BACK,   32'sd0,   5'd1, 1'b1,
      '{bdq_pkg::ST_DONE,      VAL_MAX, 4'd0, 5'd0}},
    '{bdq_pkg::OP_PUSH_FRONT, 32'sh1234_5678, 5'd7, 1'b0, '0},
    '{bdq_pkg::OP_PUSH_BACK,  32'sd0,   5'd8, 1'b0, '0},
    '{bdq_pkg::OP_PUSH_BACK,  VAL_A5,   5'd1, 1'b1,
      '{bdq_pkg::ST_DONE,      32'sd0,  4'd0, 5'd16}},
    '{bdq_pkg::OP_PUSH_FRONT, 32'sd0,   5'd1, 1'b1,
      '{bdq_pkg::ST_FULL,      32'sd0,  4'd0, 5'd16}},
    '{bdq_pkg::OP_PUSH_BACK,  VAL_MAX,  5'd1, 1'b1,
      '{bdq_pkg::ST_FULL,      32'sd0,  4'd0, 5'd16}},
    '{bdq_pkg::OP_SEARCH,     VAL_A5,   5'd1, 1'b0, '0},
    '{bdq_pkg::OP_SEARCH,     32'sd0,   5'd1, 1'b0, '0},
    '{bdq_pkg::OP_POP_FRONT,  32'sd0,   5'd1, 1'b0, '0},
    '{bdq_pkg::OP_POP_BACK,   32'sd0,   5'd1, 1'b0, '0}
  };

  bounded_deque_with_search #(.DEPTH(DEPTH)) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb_bounded_deque_with_search: done, errors");
    $finish;
  end

  function automatic bdq_pkg::out_item_t deque_apply(bdq_pkg::in_item_t it);
    bdq_pkg::out_item_t r;
    r = '0;
    r.status = bdq_pkg::ST_DONE;
    case (it.opcode)
      bdq_pkg::OP_PUSH_FRONT: begin
        if (ring_count >= DEPTH) begin
          r.status = bdq_pkg::ST_FULL;
        end else begin
          ring_front = (ring_front + DEPTH - 1) % DEPTH;
          ring_mem[ring_front] = it.value;
          ring_count++;
        end
      end
      bdq_pkg::OP_PUSH_BACK: begin
        if (ring_count >= DEPTH) begin
          r.status = bdq_pkg::ST_FULL;
        end else begin
          ring_mem[(ring_front + ring_count) % DEPTH] = it.value;
          ring_count++;
        end
      end
      bdq_pkg::OP_POP_FRONT: begin
        if (ring_count == 0) begin
          r.status = bdq_pkg::ST_EMPTY;
        end else begin
          r.removed_value = ring_mem[ring_front];
          ring_front = (ring_front + 1) % DEPTH;
          ring_count--;
        end
      end
      bdq_pkg::OP_POP_BACK: begin
        if (ring_count == 0) begin
          r.status = bdq_pkg::ST_EMPTY;
        end else begin
          r.removed_value = ring_mem[(ring_front + ring_count - 1) % DEPTH];
          ring_count--;
        end
      end
      bdq_pkg::OP_SEARCH: begin
        r.status = bdq_pkg::ST_NOT_FOUND;
        for (int i = 0; i < ring_count; i++) begin
          if (r.status == bdq_pkg::ST_NOT_FOUND &&
              ring_mem[(ring_front + i) % DEPTH] == it.value) begin
            r.status = bdq_pkg::ST_DONE;
            r.found_position = 4'(i);
          end
        end
      end
      default: begin
      end
    endcase
    r.entry_count = 5'(ring_count);
    return r;
  endfunction

  // Holds start until the beat is taken, then either keeps start high for the next beat
  // or lowers it for a random gap, or until every expected result has come in.
  task automatic drive_beat(input bdq_pkg::in_item_t it, input logic typed,
                            input bdq_pkg::out_item_t want, input logic drain);
    bdq_pkg::out_item_t guess;
    start <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    guess = deque_apply(it);
    expected_q.push_back(typed ? want : guess);
    if (drain || $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
      while (drain ? expected_q.size() != 0 : $urandom_range(99) < idle_pct) @(posedge clk);
    end
  endtask

  function automatic bdq_pkg::in_item_t pick_item(int push_bias);
    bdq_pkg::in_item_t it;
    int r;
    r = $urandom_range(99);
    if (r < 4) begin
      it.opcode = 3'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
    end else if (r < 24) begin
      it.opcode = bdq_pkg::OP_SEARCH;
    end else if (r < 24 + push_bias * 76 / 100) begin
      it.opcode = $urandom_range(1) ? bdq_pkg::OP_PUSH_BACK : bdq_pkg::OP_PUSH_FRONT;
    end else begin
      it.opcode = $urandom_range(1) ? bdq_pkg::OP_POP_BACK : bdq_pkg::OP_POP_FRONT;
    end
    it.value = ($urandom_range(99) < 60) ? hot_vals[$urandom_range(7)] : $urandom;
    return it;
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: result with nothing expected: status %0d removed %0d pos %0d count %0d",
                   $realtime, out_item.status, out_item.removed_value,
                   out_item.found_position, out_item.entry_count);
      end else begin
        bdq_pkg::out_item_t want;
        want = expected_q.pop_front();
        if (out_item.status !== want.status || out_item.removed_value !== want.removed_value ||
            out_item.found_position !== want.found_position ||
            out_item.entry_count !== want.entry_count) begin
          errors++;
          if (errors <= 10)
            $display("%0t: mismatch: want %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d", $realtime,
                     want.status, want.removed_value, want.found_position, want.entry_count,
                     out_item.status, out_item.removed_value, out_item.found_position,
                     out_item.entry_count);
        end
      end
    end
  end

  initial begin
    int push_bias;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[r]) begin
      for (int k = 0; k < plan[r].reps; k++)
        drive_beat('{plan[r].opcode, plan[r].value}, plan[r].typed, plan[r].want, 1'b0);
    end

    hot_vals[0] = VAL_MIN;
    hot_vals[1] = VAL_MAX;
    hot_vals[2] = 32'sd0;
    hot_vals[3] = VAL_ONES;
    for (int i = 4; i < 8; i++) hot_vals[i] = $urandom;

    push_bias = 50;
    for (int n = 0; n < 1000; n++) begin
      idle_pct = (n < 333) ? 29 : (n < 666) ? 60 : 0;
      if (n % 40 == 0) begin
        case ($urandom_range(2))
          0: push_bias = 85;
          1: push_bias = 15;
          default: push_bias = 50;
        endcase
      end
      drive_beat(pick_item(push_bias), 1'b0, '0, n == 332 || n == 665 || n == 999);
    end

    repeat (DEPTH + 8) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("tb_bounded_deque_with_search: done, clean");
    end else begin
      $display("tb_bounded_deque_with_search: done, errors");
    end
    $finish;
  end

endmodule
